/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the decoder RTL. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define EGBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("egbd assertion failed");

// The condition must never be true outside reset.
`define EGBD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("egbd forbidden condition seen");

`else

`define EGBD_ASSERT(lbl, clk, rst_n, prop)

`define EGBD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* design/egbd_pkg.sv */
// ----------------------------------------------------------------------------
// Exp-Golomb byte decoder package
// Shared widths, register indexes and the types passed between the front end,
// the codeword queue and the back end.
// ----------------------------------------------------------------------------
package egbd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BLK_W    = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b1;

  localparam logic [BLK_W-1:0] BLOCK_LENGTH_RST = 16'hFFFF;

  // Codeword queue geometry (depth is a power of two).
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // One completed codeword as handed from the front end to the back end.
  typedef struct packed {
    logic [BYTE_W-1:0] zero_run;
    logic [BYTE_W-1:0] suffix;
    logic              signed_mode;
  } egbd_item_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } egbd_qstat_t;

endpackage

/* design/egbd_front.sv */
// ----------------------------------------------------------------------------
// Exp-Golomb front end
// Consumes one coded bit per beat, tracks the codeword phase and pushes each
// completed codeword into the queue.
// ----------------------------------------------------------------------------
module egbd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 code_valid_i,
  input  logic                 code_bit_i,
  input  logic                 signed_mode_i,
  input  egbd_pkg::egbd_qstat_t qstat_i,
  output logic                 push_o,
  output egbd_pkg::egbd_item_t push_item_o
);
  import egbd_pkg::*;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZEROS  = 2'd1,
    PH_SUFFIX = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] zero_run_q, zero_run_d;
  logic [BYTE_W:0]   suffix_left_q, suffix_left_d;
  logic [BYTE_W-1:0] suffix_q, suffix_d;
  logic              accept;
  logic [BYTE_W-1:0] suffix_next;
  logic [BYTE_W:0]   left_next;

  assign accept      = code_valid_i && !qstat_i.full;
  assign suffix_next = {suffix_q[BYTE_W-2:0], code_bit_i};
  assign left_next   = (suffix_left_q != '0) ? suffix_left_q - 1'b1 : '0;

  always_comb begin
    phase_d       = phase_q;
    zero_run_d    = zero_run_q;
    suffix_left_d = suffix_left_q;
    suffix_d      = suffix_q;
    push_o        = 1'b0;
    push_item_o   = '{zero_run: '0, suffix: '0, signed_mode: signed_mode_i};
    if (accept) begin
      case (phase_q)
        PH_ZEROS: begin
          if (!code_bit_i) begin
            if (zero_run_q != '1) begin
              zero_run_d = zero_run_q + 1'b1;
            end
          end else begin
            suffix_left_d = {1'b0, zero_run_q} + {{BYTE_W{1'b0}}, signed_mode_i};
            suffix_d      = '0;
            phase_d       = PH_SUFFIX;
          end
        end
        PH_SUFFIX: begin
          if (left_next == '0) begin
            push_o                = 1'b1;
            push_item_o.zero_run  = zero_run_q;
            push_item_o.suffix    = suffix_next;
            phase_d               = PH_START;
            zero_run_d            = '0;
            suffix_left_d         = '0;
            suffix_d              = '0;
          end else begin
            suffix_left_d = left_next;
            suffix_d      = suffix_next;
          end
        end
        default: begin
          // Start of a codeword. A leading one is the whole codeword.
          if (code_bit_i) begin
            push_o = 1'b1;
          end else begin
            zero_run_d = BYTE_W'(1);
            phase_d    = PH_ZEROS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_START;
      zero_run_q    <= '0;
      suffix_left_q <= '0;
      suffix_q      <= '0;
    end else begin
      phase_q       <= phase_d;
      zero_run_q    <= zero_run_d;
      suffix_left_q <= suffix_left_d;
      suffix_q      <= suffix_d;
    end
  end

endmodule

/* design/egbd_queue.sv */
// ----------------------------------------------------------------------------
// Codeword queue
// Small FIFO that decouples the bit front end from the byte back end.
// ----------------------------------------------------------------------------
module egbd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  egbd_pkg::egbd_item_t  push_item_i,
  input  logic                  pop_i,
  output egbd_pkg::egbd_item_t  head_o,
  output egbd_pkg::egbd_qstat_t qstat_o
);
  import egbd_pkg::*;

  egbd_item_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* design/egbd_back.sv */
// ----------------------------------------------------------------------------
// Exp-Golomb back end
// Turns a queued codeword into a byte, tracks the block count and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module egbd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  egbd_pkg::egbd_item_t       head_i,
  input  egbd_pkg::egbd_qstat_t      qstat_i,
  input  logic [egbd_pkg::BLK_W-1:0] block_length_i,
  input  logic                       out_stall_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  output logic [egbd_pkg::BYTE_W-1:0] decoded_byte_o,
  output logic                       last_of_block_o
);
  import egbd_pkg::*;

  logic              out_valid_q;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [BLK_W-1:0]  bytes_done_q, bytes_done_d;
  logic [BYTE_W-1:0] offset, mag;
  logic [BLK_W:0]    done_inc;

  assign pop_o = !qstat_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    // Offset 2^n - 1 modulo 256; it is all ones once n reaches the byte width.
    if (head_i.zero_run < BYTE_W'(BYTE_W)) begin
      offset = (BYTE_W'(1) << head_i.zero_run[$clog2(BYTE_W)-1:0]) - BYTE_W'(1);
    end else begin
      offset = '1;
    end
    mag = {1'b0, head_i.suffix[BYTE_W-1:1]} + offset;
    if (!head_i.signed_mode) begin
      byte_d = head_i.suffix + offset;
    end else if (head_i.suffix[0]) begin
      byte_d = ~mag + BYTE_W'(1);
    end else begin
      byte_d = mag;
    end
    done_inc     = {1'b0, bytes_done_q} + (BLK_W+1)'(1);
    last_d       = (done_inc >= {1'b0, block_length_i});
    bytes_done_d = last_d ? '0 : done_inc[BLK_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      bytes_done_q <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q  <= 1'b1;
        bytes_done_q <= bytes_done_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_byte_o  = byte_q;
  assign last_of_block_o = last_q;

endmodule

/* design/exp_golomb_byte_decoder.sv */
// A finished codeword is queued, then popped by the back end into the output register.
// Throughput: one coded bit per cycle while the codeword queue is not full.
// A two-entry codeword queue lets the front take bits during an output stall until it fills.
// Reset (rst_ni low, asynchronous) clears phase, counters, queue and output valid.
// After reset signed_mode is 0 and block_length is 65535.
// ----------------------------------------------------------------------------
// Exp-Golomb byte decoder
// Top level: configuration registers, front end, codeword queue and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module exp_golomb_byte_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [egbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [egbd_pkg::CFG_W-1:0]     cfg_data_i,
  // Coded bit input channel.
  input  logic                           code_valid_i,
  output logic                           code_stall_o,
  input  logic                           code_bit_i,
  // Decoded byte output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [egbd_pkg::BYTE_W-1:0]    decoded_byte_o,
  output logic                           last_of_block_o
);
  import egbd_pkg::*;

  // Configuration registers. The user must see that they are only written while the
  // decoder is idle, so the front and back may sample them directly; nothing here checks it.
  logic             signed_mode_q;
  logic [BLK_W-1:0] block_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q  <= 1'b0;
      block_length_q <= BLOCK_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIGNED_MODE:  signed_mode_q  <= cfg_data_i[0];
        REG_BLOCK_LENGTH: block_length_q <= cfg_data_i[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  logic        push;
  logic        pop;
  egbd_item_t  push_item;
  egbd_item_t  head;
  egbd_qstat_t qstat;

  // The input side stalls only when the codeword queue is full, so a bit beat
  // is taken every cycle while the back end keeps draining the queue.
  assign code_stall_o = qstat.full;

  // The front end walks the codeword one bit per beat: leading zeros are
  // counted (saturating), then the suffix is shifted in, and a complete
  // codeword is pushed along with the signed mode in force at that moment.
  egbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .code_valid_i  (code_valid_i),
    .code_bit_i    (code_bit_i),
    .signed_mode_i (signed_mode_q),
    .qstat_i       (qstat),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  egbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  // The back end forms the byte from the queued codeword, counts bytes in the
  // current block and flags the last one, holding the beat until it is taken.
  egbd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .qstat_i         (qstat),
    .block_length_i  (block_length_q),
    .out_stall_i     (out_stall_i),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .decoded_byte_o  (decoded_byte_o),
    .last_of_block_o (last_of_block_o)
  );

  // A codeword is never pushed into a full queue.
  `EGBD_ASSERT(a_no_overflow, clk_i, rst_ni, push |-> !qstat.full)
  // The back end never pops an empty queue.
  `EGBD_ASSERT(a_no_underflow, clk_i, rst_ni, pop |-> !qstat.empty)
  // The queue flags never claim full and empty together.
  `EGBD_ASSERT_NEVER(a_flags_consistent, clk_i, rst_ni, qstat.full && qstat.empty)

endmodule

/* bench/exp_golomb_byte_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exp-Golomb byte decoder testbench
// Streams coded bits into the decoder through a queue-fed driver, predicts
// every decoded byte and its block flag with a bit-serial model kept in the
// bench, and compares each output beat in order. Configuration changes happen
// between phases, once the output side has drained.
// ----------------------------------------------------------------------------
module exp_golomb_byte_decoder_tb;
  import egbd_pkg::*;

  // Codeword parser states of the bench model. The fourth encoding is never
  // entered and is treated like the start of a codeword.
  typedef enum logic [1:0] {
    CW_START  = 2'd0,
    CW_ZEROS  = 2'd1,
    CW_SUFFIX = 2'd2
  } cw_phase_e;

  // One decoded output beat.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } decoded_t;

  // All block inputs start at known values before the first clock edge.
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_W-1:0]      cfg_data_i   = '0;
  logic                  code_valid_i = 1'b0;
  logic                  code_bit_i   = 1'b0;
  logic                  out_stall_i  = 1'b0;
  logic                  code_stall_o;
  logic                  out_valid_o;
  logic [BYTE_W-1:0]     decoded_byte_o;
  logic                  last_of_block_o;

  exp_golomb_byte_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .code_valid_i    (code_valid_i),
    .code_stall_o    (code_stall_o),
    .code_bit_i      (code_bit_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .decoded_byte_o  (decoded_byte_o),
    .last_of_block_o (last_of_block_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic        bitstream_q[$];   // coded bits waiting to be offered
  decoded_t    decoded_fifo[$];  // bytes the model has decoded, oldest first
  decoded_t    want;
  int unsigned stim_total   = 0;
  int unsigned fail_count   = 0;

  // Traffic shaping, set by the sequence at falling edges.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          calm          = 1'b0;  // no idling at all in the closing phase
  int unsigned holds_asked   = 0;     // long receiver hold-offs requested
  bit          gen_signed    = 1'b0;  // mode the stimulus generator assumes

  // Model copy of the configuration and of the parser state.
  logic              cfg_signed  = 1'b0;
  logic [BLK_W-1:0]  cfg_blk_len = BLOCK_LENGTH_RST;
  cw_phase_e         cw_phase    = CW_START;
  logic [7:0]        run_len     = '0;
  logic [8:0]        sfx_left    = '0;
  logic [7:0]        sfx_val     = '0;
  logic [BLK_W-1:0]  blk_count   = '0;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // Hands a finished byte to the expectation queue, tags it with the block
  // flag and returns the parser to the start of a codeword. The block test is
  // done in 17 bits so that a length of 0 flags every byte.
  function automatic void emit_byte(input logic [BYTE_W-1:0] value);
    decoded_t d;
    logic     last;
    last      = ({1'b0, blk_count} + 17'd1 >= {1'b0, cfg_blk_len});
    blk_count = last ? '0 : blk_count + 16'd1;
    d.value   = value;
    d.last    = last;
    decoded_fifo.push_back(d);
    cw_phase  = CW_START;
    run_len   = '0;
    sfx_left  = '0;
    sfx_val   = '0;
  endfunction

  // Advances the model by one accepted coded bit.
  function automatic void decode_bit(input logic b);
    logic [BYTE_W-1:0] off;
    logic [BYTE_W-1:0] mag;
    case (cw_phase)
      CW_ZEROS: begin
        if (!b) begin
          // The zero count sticks at 255.
          if (run_len != 8'hFF) run_len = run_len + 8'd1;
        end else begin
          // The suffix length is fixed by the mode in force right now.
          sfx_left = {1'b0, run_len} + {8'd0, cfg_signed};
          sfx_val  = '0;
          cw_phase = CW_SUFFIX;
        end
      end
      CW_SUFFIX: begin
        // Only the low byte of a long suffix survives, but every bit counts.
        sfx_val = {sfx_val[6:0], b};
        if (sfx_left != 0) sfx_left = sfx_left - 9'd1;
        if (sfx_left == 0) begin
          // 2^n - 1 modulo 256; for n of 8 and more this is 255.
          off = (run_len < 8) ? (8'd1 << run_len) - 8'd1 : 8'hFF;
          // The mode at the moment of emission picks the final mapping.
          if (!cfg_signed) begin
            emit_byte(off + sfx_val);
          end else begin
            mag = (sfx_val >> 1) + off;
            emit_byte(sfx_val[0] ? 8'd0 - mag : mag);
          end
        end
      end
      default: begin
        // A leading one is the whole codeword for byte 0.
        if (b) begin
          emit_byte('0);
        end else begin
          run_len  = 8'd1;
          cw_phase = CW_ZEROS;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: checks output beats first, then feeds the model with the input
  // beat and any register write of the same edge. A write takes effect after
  // the edge, so a bit accepted at that edge still sees the old setting.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_signed  = 1'b0;
      cfg_blk_len = BLOCK_LENGTH_RST;
      cw_phase    = CW_START;
      run_len     = '0;
      sfx_left    = '0;
      sfx_val     = '0;
      blk_count   = '0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_fifo.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected byte %02h last %b", $realtime,
                     decoded_byte_o, last_of_block_o);
          fail_count++;
        end else begin
          want = decoded_fifo.pop_front();
          if (want.value !== decoded_byte_o || want.last !== last_of_block_o) begin
            if (fail_count < 10)
              $display("[%0t] mismatch: byte exp %02h got %02h, last exp %b got %b",
                       $realtime, want.value, decoded_byte_o, want.last,
                       last_of_block_o);
            fail_count++;
          end
        end
      end
      if (code_valid_i && !code_stall_o) decode_bit(code_bit_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIGNED_MODE:  cfg_signed  = cfg_data_i[0];
          REG_BLOCK_LENGTH: cfg_blk_len = cfg_data_i[BLK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Bit driver: offers the head of the bit queue and retires it on the beat.
  // A stalled beat holds. Random idle bursts start between beats, and the data line
  // carries noise while valid is low.
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_valid_i <= 1'b0;
      code_bit_i   <= 1'b0;
      send_gap     = 0;
    end else begin
      if (code_valid_i && !code_stall_o) void'(bitstream_q.pop_front());
      if (code_valid_i && code_stall_o) begin
        // Hold the stalled beat as it is.
      end else if (send_gap > 0) begin
        send_gap--;
        code_valid_i <= 1'b0;
        code_bit_i   <= 1'($urandom_range(1));
      end else if (bitstream_q.size() > 0 && !calm &&
                   $urandom_range(99) < send_idle_pct) begin
        send_gap     = $urandom_range(5);
        code_valid_i <= 1'b0;
        code_bit_i   <= 1'($urandom_range(1));
      end else if (bitstream_q.size() > 0) begin
        code_valid_i <= 1'b1;
        code_bit_i   <= bitstream_q[0];
      end else begin
        code_valid_i <= 1'b0;
        code_bit_i   <= 1'($urandom_range(1));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall: random bursts, plus long hold-offs on request that let the
  // decoder fill up and push back on its input.
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      hold_left   = 0;
      holds_done  = 0;
    end else begin
      if (hold_left == 0 && holds_done != holds_asked) begin
        holds_done++;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(99) < recv_idle_pct) begin
        stall_left  = $urandom_range(5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_bit(input logic b);
    bitstream_q.push_back(b);
    stim_total++;
  endfunction

  // Pushes len bits of pat, most significant first.
  function automatic void push_pattern(input logic [31:0] pat, input int unsigned len);
    int unsigned k;
    for (k = len; k > 0; k--) push_bit(pat[k-1]);
  endfunction

  // One well-formed codeword with n leading zeros and a random suffix whose
  // length follows the saturated zero count and the assumed mode.
  function automatic void push_codeword(input int unsigned n, input bit sgn);
    int unsigned k;
    int unsigned len;
    for (k = 0; k < n; k++) push_bit(1'b0);
    push_bit(1'b1);
    if (n > 0) begin
      len = ((n > 255) ? 255 : n) + sgn;
      for (k = 0; k < len; k++) push_bit(1'($urandom_range(1)));
    end
  endfunction

  // Mostly well-formed codewords with a spread of prefix lengths; a small
  // share of random bits throws the stream out of step now and then.
  function automatic void push_traffic(input int unsigned nbits);
    int unsigned start;
    int unsigned r;
    int unsigned k;
    start = stim_total;
    while (stim_total - start < nbits) begin
      r = $urandom_range(99);
      if (r < 8) begin
        for (k = $urandom_range(5, 1); k > 0; k--) push_bit(1'($urandom_range(1)));
      end else if (r < 35) begin
        push_codeword(0, gen_signed);
      end else if (r < 88) begin
        push_codeword($urandom_range(7, 1), gen_signed);
      end else begin
        push_codeword($urandom_range(14, 8), gen_signed);
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // The mode register only keeps bit 0; the upper data bits are noise.
  task automatic set_mode(input bit sgn);
    gen_signed = sgn;
    write_reg(REG_SIGNED_MODE, {CFG_W'($urandom_range(16'h7FFF)) << 1} | CFG_W'(sgn));
  endtask

  // Waits until every bit has been taken and every byte has come out, then
  // waits on past the codeword queue and the output register. The guard keeps
  // a lost byte from hanging the run; the leftover is caught at the end.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    while ((bitstream_q.size() != 0 || code_valid_i || decoded_fifo.size() != 0) &&
           guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned p;
    logic [BLK_W-1:0] blen;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: unsigned, long blocks. Byte 0 from a lone one, then
    // n = 1 with suffix 0 and n = 2 with suffix 11.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    @(negedge clk_i);
    push_pattern(32'b1_010_00111, 9);
    drain();

    // Signed, every byte last: +1, -1, then stop right after the terminating
    // one of a codeword with n = 2 so that its suffix length is already fixed.
    set_mode(1'b1);
    write_reg(REG_BLOCK_LENGTH, 16'd1);
    @(negedge clk_i);
    push_pattern(32'b0100_0101_001, 11);
    drain();

    // Switch to unsigned mid-codeword: the three suffix bits finish with the
    // unsigned mapping. Block length 0 flags every byte. Then leave the parser
    // in the middle of a zero run.
    set_mode(1'b0);
    write_reg(REG_BLOCK_LENGTH, 16'd0);
    @(negedge clk_i);
    push_pattern(32'b101_00, 5);
    drain();

    // The terminating one now sees signed mode and reads three suffix bits.
    set_mode(1'b1);
    write_reg(REG_BLOCK_LENGTH, 16'd3);
    @(negedge clk_i);
    push_pattern(32'b1_110, 4);
    drain();

    // Shorten the block to the running count; the next byte closes it.
    // A zero run far past 255 saturates the count, and the suffix keeps only
    // its low byte.
    write_reg(REG_BLOCK_LENGTH, 16'd1);
    gen_signed = 1'b1;
    @(negedge clk_i);
    push_codeword(1, 1'b1);
    push_codeword(257, 1'b1);
    push_codeword(3, 1'b1);
    drain();

    // Long receiver hold-off while the sender keeps offering: the decoder
    // fills up and has to stall its input.
    set_mode(1'b0);
    write_reg(REG_BLOCK_LENGTH, 16'd5);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    push_pattern(32'hFFFF_FFFF, 16);
    push_traffic(10);
    drain();

    // Random phases; each one ends drained, so the sender pauses until every
    // byte is out before the settings change.
    for (p = 0; p < 5; p++) begin
      case ($urandom_range(7))
        0:       blen = 16'd1;
        1:       blen = 16'd2;
        2:       blen = 16'd0;
        3:       blen = 16'hFFFF;
        4:       blen = BLK_W'($urandom_range(12, 3));
        5:       blen = BLK_W'($urandom_range(40, 13));
        6:       blen = BLK_W'($urandom_range(16'hFFFF));
        default: blen = BLK_W'($urandom_range(8, 1));
      endcase
      if ($urandom_range(1)) begin
        set_mode(1'($urandom_range(1)));
        write_reg(REG_BLOCK_LENGTH, blen);
      end else begin
        write_reg(REG_BLOCK_LENGTH, blen);
        set_mode(1'($urandom_range(1)));
      end
      @(negedge clk_i);
      case ($urandom_range(2))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(2))
        0:       recv_idle_pct = 0;
        1:       recv_idle_pct = 15;
        default: recv_idle_pct = 40;
      endcase
      push_traffic(10);
      drain();
    end

    // Closing phase at full rate on both sides.
    set_mode(1'($urandom_range(1)));
    write_reg(REG_BLOCK_LENGTH, CFG_W'($urandom_range(9, 2)));
    @(negedge clk_i);
    calm = 1'b1;
    push_traffic(20);
    drain();

    if (fail_count == 0 && decoded_fifo.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
